@@ hdl/itoa_pkg.sv @@
`default_nettype none

package itoa_pkg;

   localparam int BIN_W         = 64;
   localparam int DIGIT_CAP     = 20;
   localparam int DIGS_W        = DIGIT_CAP * 4;
   localparam int NDIG_W        = 5;
   localparam int WIDTH_W       = 6;
   localparam int MAX_WIDTH_DEF = 62;
   localparam int BITS_PER_STEP = 2;
   localparam int DABBLE_STEPS  = BIN_W / BITS_PER_STEP;
   localparam int STEP_W        = $clog2(DABBLE_STEPS);

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_UP_A  = 8'h41;
   localparam logic [7:0] CH_LO_A  = 8'h61;
   localparam logic [7:0] CH_UP_X  = 8'h58;
   localparam logic [7:0] CH_LO_X  = 8'h78;

   // Commands from the sequencer to the digit unit.
   typedef struct packed {
      logic             start;
      logic             neg;
      logic             hex;
      logic             pop;
   } conv_ctl_type;

   // Status from the digit unit.
   typedef struct packed {
      logic              done;
      logic [NDIG_W-1:0] ndig;
      logic [3:0]        top;
   } conv_stat_type;

endpackage

`default_nettype wire

@@ hdl/integer_to_ascii_formatter.sv @@
`default_nettype none

// Integer to ASCII formatter. Each request carries a 64-bit value with its
// format options and produces its text on the rsp_ channel, one character per
// response, rsp_last high on the final one. The text is
// [spaces][minus][0x|0X][zeros][digits]: space padding leaves the minus just
// before the digits and does not count the hex prefix toward the width, zero
// padding puts minus and prefix first and counts them. Widths above MAX_WIDTH
// saturate; a zero value prints "0". The minus is printed only for signed
// decimal. Timing: one request at a time, req_ready is low while a number is
// in progress. Decimal digits come from a shift-and-add-3 unit working two
// bits per cycle; hex loads its nibbles directly. A normalize pass then drops
// leading zeros, one digit per cycle, and then hands the digits over.
// Characters then leave at one per cycle while rsp_ready is high, except
// where the text changes phase between padding, sign, prefix and digits;
// after the last one the block returns to idle before the next request.
module integer_to_ascii_formatter #(
   parameter int MAX_WIDTH = itoa_pkg::MAX_WIDTH_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output      logic                            req_ready,
   input  wire logic [itoa_pkg::BIN_W-1:0]      req_value,
   input  wire logic                            req_is_signed,
   input  wire logic                            req_base_hex,
   input  wire logic                            req_upper_case,
   input  wire logic                            req_hex_prefix,
   input  wire logic                            req_zero_pad,
   input  wire logic [itoa_pkg::WIDTH_W-1:0]    req_width,
   output      logic                            rsp_valid,
   input  wire logic                            rsp_ready,
   output      logic [7:0]                      rsp_ch,
   output      logic                            rsp_last
);
   import itoa_pkg::*;

   localparam logic [WIDTH_W-1:0] MAX_W = WIDTH_W'(MAX_WIDTH);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_SPACE,
      ST_SIGN,
      ST_PFX0,
      ST_PFXX,
      ST_ZERO,
      ST_DIGIT
   } state_type;

   state_type            state_ff, state_in;
   logic                 neg_ff, neg_in;
   logic                 pfx_ff, pfx_in;
   logic                 zp_ff, zp_in;
   logic                 up_ff, up_in;
   logic [WIDTH_W-1:0]   w_ff, w_in;
   logic [WIDTH_W-1:0]   spc_ff, spc_in;
   logic [WIDTH_W-1:0]   zro_ff, zro_in;
   logic [NDIG_W-1:0]    dcnt_ff, dcnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           rsp_ch_ff, rsp_ch_in;
   logic                 rsp_last_ff, rsp_last_in;

   conv_ctl_type         ctl;
   conv_stat_type        stat;

   logic                 accept;
   logic                 can_emit;
   logic [WIDTH_W-1:0]   n_ext;
   logic [WIDTH_W-1:0]   field;
   logic [WIDTH_W-1:0]   fmn;
   logic [WIDTH_W-1:0]   head;
   logic [7:0]           dig_ch;

   assign accept   = req_valid && req_ready;
   assign can_emit = !rsp_valid_ff || rsp_ready;

   // Field layout, valid once the digit unit reports done.
   assign n_ext = WIDTH_W'(stat.ndig);
   assign field = (w_ff < n_ext) ? n_ext : w_ff;
   assign fmn   = field - n_ext;
   assign head  = WIDTH_W'(neg_ff) + (pfx_ff ? WIDTH_W'(2) : WIDTH_W'(0));

   assign dig_ch = (stat.top < 4'd10) ? (CH_ZERO + 8'(stat.top))
                 : ((up_ff ? CH_UP_A : CH_LO_A) + 8'(stat.top - 4'd10));

   assign ctl.start = accept;
   assign ctl.neg   = req_is_signed && !req_base_hex && req_value[BIN_W-1];
   assign ctl.hex   = req_base_hex;
   assign ctl.pop   = (state_ff == ST_DIGIT) && can_emit;

   itoa_conv u_conv (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .value (req_value),
      .stat  (stat)
   );

   always_comb begin
      state_in     = state_ff;
      neg_in       = neg_ff;
      pfx_in       = pfx_ff;
      zp_in        = zp_ff;
      up_in        = up_ff;
      w_in         = w_ff;
      spc_in       = spc_ff;
      zro_in       = zro_ff;
      dcnt_in      = dcnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_ch_in    = rsp_ch_ff;
      rsp_last_in  = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               // latch options, saturate width
               neg_in   = ctl.neg;
               pfx_in   = req_base_hex && req_hex_prefix;
               zp_in    = req_zero_pad;
               up_in    = req_upper_case;
               w_in     = (req_width > MAX_W) ? MAX_W : req_width;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            if (stat.done) begin
               dcnt_in = stat.ndig;
               if (zp_ff) begin
                  spc_in = '0;
                  zro_in = (fmn > head) ? (fmn - head) : '0;
               end else begin
                  // the minus takes the place of the last space
                  spc_in = (fmn > WIDTH_W'(neg_ff)) ? (fmn - WIDTH_W'(neg_ff)) : '0;
                  zro_in = '0;
               end
               state_in = ST_SPACE;
            end
         end
         ST_SPACE: begin
            if (spc_ff == '0) begin
               state_in = ST_SIGN;
            end else if (can_emit) begin
               rsp_valid_in = 1'b1;
               rsp_ch_in    = CH_SPACE;
               rsp_last_in  = 1'b0;
               spc_in       = spc_ff - WIDTH_W'(1);
            end
         end
         ST_SIGN: begin
            if (!neg_ff) begin
               state_in = ST_PFX0;
            end else if (can_emit) begin
               rsp_valid_in = 1'b1;
               rsp_ch_in    = CH_MINUS;
               rsp_last_in  = 1'b0;
               state_in     = ST_PFX0;
            end
         end
         ST_PFX0: begin
            if (!pfx_ff) begin
               state_in = ST_ZERO;
            end else if (can_emit) begin
               rsp_valid_in = 1'b1;
               rsp_ch_in    = CH_ZERO;
               rsp_last_in  = 1'b0;
               state_in     = ST_PFXX;
            end
         end
         ST_PFXX: begin
            if (can_emit) begin
               rsp_valid_in = 1'b1;
               rsp_ch_in    = up_ff ? CH_UP_X : CH_LO_X;
               rsp_last_in  = 1'b0;
               state_in     = ST_ZERO;
            end
         end
         ST_ZERO: begin
            if (zro_ff == '0) begin
               state_in = ST_DIGIT;
            end else if (can_emit) begin
               rsp_valid_in = 1'b1;
               rsp_ch_in    = CH_ZERO;
               rsp_last_in  = 1'b0;
               zro_in       = zro_ff - WIDTH_W'(1);
            end
         end
         ST_DIGIT: begin
            if (can_emit) begin
               rsp_valid_in = 1'b1;
               rsp_ch_in    = dig_ch;
               rsp_last_in  = (dcnt_ff == NDIG_W'(1));
               dcnt_in      = dcnt_ff - NDIG_W'(1);
               if (dcnt_ff == NDIG_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      neg_ff      <= neg_in;
      pfx_ff      <= pfx_in;
      zp_ff       <= zp_in;
      up_ff       <= up_in;
      w_ff        <= w_in;
      spc_ff      <= spc_in;
      zro_ff      <= zro_in;
      dcnt_ff     <= dcnt_in;
      rsp_ch_ff   <= rsp_ch_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_ch    = rsp_ch_ff;
   assign rsp_last  = rsp_last_ff;

endmodule

`default_nettype wire

@@ hdl/itoa_conv.sv @@
`default_nettype none

module itoa_conv (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire itoa_pkg::conv_ctl_type        ctl,
   input  wire logic [itoa_pkg::BIN_W-1:0]    value,
   output      itoa_pkg::conv_stat_type       stat
);
   import itoa_pkg::*;

   typedef enum logic [1:0] {
      CV_IDLE,
      CV_DABBLE,
      CV_NORM,
      CV_HOLD
   } cv_state_type;

   cv_state_type         state_ff, state_in;
   logic [BIN_W-1:0]     bin_ff, bin_in;
   logic [DIGS_W-1:0]    bcd_ff, bcd_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [NDIG_W-1:0]    ndig_ff, ndig_in;

   logic [BIN_W-1:0]     mag;
   logic [BIN_W-1:0]     bin_dab;
   logic [DIGS_W-1:0]    bcd_dab;

   assign mag = ctl.neg ? (~value + BIN_W'(1)) : value;

   // Shift-and-add-3 binary to BCD, two bits per cycle.
   always_comb begin
      logic [BIN_W-1:0]  b;
      logic [DIGS_W-1:0] d;
      b = bin_ff;
      d = bcd_ff;
      for (int k = 0; k < BITS_PER_STEP; k++) begin
         for (int i = 0; i < DIGIT_CAP; i++) begin
            if (d[i*4 +: 4] >= 4'd5) begin
               d[i*4 +: 4] = d[i*4 +: 4] + 4'd3;
            end
         end
         d = {d[DIGS_W-2:0], b[BIN_W-1]};
         b = {b[BIN_W-2:0], 1'b0};
      end
      bin_dab = b;
      bcd_dab = d;
   end

   always_comb begin
      state_in = state_ff;
      bin_in   = bin_ff;
      bcd_in   = bcd_ff;
      step_in  = step_ff;
      ndig_in  = ndig_ff;
      if (ctl.start) begin
         step_in = '0;
         ndig_in = NDIG_W'(DIGIT_CAP);
         if (ctl.hex) begin
            bcd_in   = DIGS_W'(value);
            bin_in   = '0;
            state_in = CV_NORM;
         end else begin
            bcd_in   = '0;
            bin_in   = mag;
            state_in = CV_DABBLE;
         end
      end else begin
         case (state_ff)
            CV_DABBLE: begin
               bin_in  = bin_dab;
               bcd_in  = bcd_dab;
               step_in = step_ff + STEP_W'(1);
               if (step_ff == STEP_W'(DABBLE_STEPS - 1)) begin
                  state_in = CV_NORM;
               end
            end
            CV_NORM: begin
               // drop leading zero digits, keep at least one
               if (bcd_ff[DIGS_W-1 -: 4] == 4'd0 && ndig_ff > NDIG_W'(1)) begin
                  bcd_in  = {bcd_ff[DIGS_W-5:0], 4'd0};
                  ndig_in = ndig_ff - NDIG_W'(1);
               end else begin
                  state_in = CV_HOLD;
               end
            end
            CV_HOLD: begin
               if (ctl.pop) begin
                  bcd_in = {bcd_ff[DIGS_W-5:0], 4'd0};
               end
            end
            default: begin
               state_in = CV_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CV_IDLE;
      end else begin
         state_ff <= state_in;
      end
      bin_ff  <= bin_in;
      bcd_ff  <= bcd_in;
      step_ff <= step_in;
      ndig_ff <= ndig_in;
   end

   assign stat.done = (state_ff == CV_HOLD);
   assign stat.ndig = ndig_ff;
   assign stat.top  = bcd_ff[DIGS_W-1 -: 4];

endmodule

`default_nettype wire
